// ----- sv/leb_pkg.sv -----
// Shared types and constants of the line edit buffer.
package leb_pkg;

  localparam int MAX_CHARS_DEF = 64;
  localparam int CAP_W = 7;
  localparam int POS_W = 6;
  localparam int CHAR_W = 8;
  localparam int KIND_W = 3;
  localparam int IDX_W = 8;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
  localparam logic [POS_W-1:0] START_RESET = 6'd0;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE   = 3'd0,
    KIND_LEFT   = 3'd1,
    KIND_RIGHT  = 3'd2,
    KIND_BKSP   = 3'd3,
    KIND_INSERT = 3'd4,
    KIND_READ   = 3'd5,
    KIND_CLEAR  = 3'd6,
    KIND_SPARE  = 3'd7
  } kind_t;

  typedef enum logic {
    CFG_CAPACITY = 1'b0,
    CFG_START    = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic              ins;
    logic              del;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  cursor;
  } cell_ctrl_t;

endpackage

// ----- sv/leb_cell.sv -----
// One character cell of the edit line, shifting toward either neighbor.
module leb_cell #(
  parameter int INDEX = 0
) (
  input  logic                      clk,
  input  leb_pkg::cell_ctrl_t       ctrl,
  input  logic [leb_pkg::CHAR_W-1:0] left_char,
  input  logic [leb_pkg::CHAR_W-1:0] right_char,
  output logic [leb_pkg::CHAR_W-1:0] held_char
);
  import leb_pkg::*;

  localparam logic [IDX_W:0] MY_IDX = (IDX_W + 1)'(INDEX);

  logic [IDX_W:0]  cur_ext;
  logic [CHAR_W-1:0] held_char_next;

  assign cur_ext = {1'b0, ctrl.cursor};

  always_comb begin
    held_char_next = held_char;
    if (ctrl.ins) begin
      if (MY_IDX > cur_ext) begin
        held_char_next = left_char;
      end else if (MY_IDX == cur_ext) begin
        held_char_next = ctrl.ch;
      end
    end else if (ctrl.del) begin
      if (MY_IDX + 1'b1 >= cur_ext) begin
        held_char_next = right_char;
      end
    end
  end

  always_ff @(posedge clk) begin
    held_char <= held_char_next;
  end

endmodule

// ----- sv/leb_cell_row.sv -----
// Row of character cells chained to their neighbors.
module leb_cell_row #(
  parameter int NUM_CELLS = leb_pkg::MAX_CHARS_DEF
) (
  input  logic                       clk,
  input  leb_pkg::cell_ctrl_t        ctrl,
  output logic [leb_pkg::CHAR_W-1:0] chars [NUM_CELLS]
);
  import leb_pkg::*;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    logic [CHAR_W-1:0] left_char;
    logic [CHAR_W-1:0] right_char;

    if (i == 0) begin : g_first
      assign left_char = '0;
    end else begin : g_mid_left
      assign left_char = chars[i-1];
    end

    if (i == NUM_CELLS - 1) begin : g_last
      assign right_char = chars[i];
    end else begin : g_mid_right
      assign right_char = chars[i+1];
    end

    leb_cell #(
      .INDEX(i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .left_char (left_char),
      .right_char(right_char),
      .held_char (chars[i])
    );
  end

endmodule

// ----- sv/line_edit_buffer_top.sv -----
// Line edit buffer with cursor: cell row, length and cursor control, result register.
// A result appears in the cycle after its request is accepted.
// Throughput: one request per cycle; insert and backspace shift cells in that cycle.
// The input stalls only while the held result is itself stalled.
// Reset clears length, cursor and the result valid and restores both registers.
// Character cells are not reset; cells at or beyond the length are never returned.
module line_edit_buffer_top #(
  parameter int MAX_CHARS = leb_pkg::MAX_CHARS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [leb_pkg::KIND_W-1:0] kind,
  input  logic [leb_pkg::CHAR_W-1:0] char_code,
  input  logic [leb_pkg::POS_W-1:0]  read_position,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [leb_pkg::POS_W-1:0]  text_length,
  output logic [leb_pkg::POS_W-1:0]  cursor_position,
  output logic [leb_pkg::CHAR_W-1:0] read_char,
  output logic                       changed,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [leb_pkg::CAP_W-1:0]  cfg_data
);
  import leb_pkg::*;

  localparam int LW = $clog2(MAX_CHARS);
  localparam int CW = (LW + 1 > CAP_W) ? LW + 1 : CAP_W;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_CHARS);

  logic [LW-1:0]    length;
  logic [LW-1:0]    cursor;
  logic [LW-1:0]    length_next;
  logic [LW-1:0]    cursor_next;
  logic [CAP_W-1:0] capacity;
  logic [POS_W-1:0] start;

  logic              accept;
  logic [CW-1:0]     len_ext;
  logic [CW-1:0]     cur_ext;
  logic [CW-1:0]     start_ext;
  logic [CW-1:0]     cap_ext;
  logic [CW-1:0]     usable;
  logic [CW-1:0]     pos_ext;
  logic [CW-1:0]     len_out;
  logic [CW-1:0]     cur_out;
  logic [LW-1:0]     rd_idx;
  logic              left_ok;
  logic              right_ok;
  logic              bksp_ok;
  logic              ins_ok;
  logic              rd_hit;
  logic              chg;
  logic [CHAR_W-1:0] rd;
  cell_ctrl_t        ctrl;
  logic [CHAR_W-1:0] chars [MAX_CHARS];

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;

  assign len_ext   = CW'(length);
  assign cur_ext   = CW'(cursor);
  assign start_ext = CW'(start);
  assign cap_ext   = CW'(capacity);
  assign usable    = (cap_ext > MAX_C) ? MAX_C : cap_ext;
  assign pos_ext   = CW'(read_position);
  assign rd_idx    = pos_ext[LW-1:0];

  assign left_ok  = cur_ext > start_ext;
  assign right_ok = cur_ext + 1'b1 < len_ext;
  assign bksp_ok  = (cur_ext > start_ext) && (cursor != '0) && (length != '0);
  assign ins_ok   = (len_ext + 1'b1 < usable) && (cur_ext <= len_ext);
  assign rd_hit   = (pos_ext < len_ext) && (pos_ext < MAX_C);

  always_comb begin
    length_next = length;
    cursor_next = cursor;
    chg         = 1'b0;
    rd          = '0;
    ctrl.ins    = 1'b0;
    ctrl.del    = 1'b0;
    ctrl.ch     = char_code;
    ctrl.cursor = IDX_W'(cursor);
    unique case (kind_t'(kind))
      KIND_LEFT: begin
        if (left_ok) begin
          cursor_next = cursor - 1'b1;
          chg         = 1'b1;
        end
      end
      KIND_RIGHT: begin
        if (right_ok) begin
          cursor_next = cursor + 1'b1;
          chg         = 1'b1;
        end
      end
      KIND_BKSP: begin
        if (bksp_ok) begin
          ctrl.del    = accept;
          cursor_next = cursor - 1'b1;
          length_next = length - 1'b1;
          chg         = 1'b1;
        end
      end
      KIND_INSERT: begin
        if (ins_ok) begin
          ctrl.ins    = accept;
          cursor_next = cursor + 1'b1;
          length_next = length + 1'b1;
          chg         = 1'b1;
        end
      end
      KIND_READ: begin
        if (rd_hit) begin
          rd = chars[rd_idx];
        end
      end
      KIND_CLEAR: begin
        chg         = (length != '0) || (cursor != '0);
        length_next = '0;
        cursor_next = '0;
      end
      KIND_NONE, KIND_SPARE: begin
        chg = 1'b0;
      end
      default: begin
        chg = 1'b0;
      end
    endcase
  end

  assign len_out = CW'(length_next);
  assign cur_out = CW'(cursor_next);

  leb_cell_row #(
    .NUM_CELLS(MAX_CHARS)
  ) u_row (
    .clk  (clk),
    .ctrl (ctrl),
    .chars(chars)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      length    <= '0;
      cursor    <= '0;
      capacity  <= CAP_RESET;
      start     <= START_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_CAPACITY: capacity <= cfg_data;
          CFG_START:    start    <= cfg_data[POS_W-1:0];
          default:      capacity <= capacity;
        endcase
      end
      if (accept) begin
        length    <= length_next;
        cursor    <= cursor_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      text_length     <= len_out[POS_W-1:0];
      cursor_position <= cur_out[POS_W-1:0];
      read_char       <= rd;
      changed         <= chg;
    end
  end

  a_cursor_in_line: assert property (@(posedge clk) disable iff (rst) cur_ext <= len_ext)
    else $error("cursor beyond line length");

  a_length_bound: assert property (@(posedge clk) disable iff (rst) len_ext < MAX_C)
    else $error("line length reached cell count");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted request produced no result");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled without a pending result");

endmodule

// ----- sim/line_status_checker.sv -----
// Checker that predicts the line, length and cursor after each request and compares results.
module line_status_checker
  import leb_pkg::*;
#(
  parameter int MAX_CHARS = MAX_CHARS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [KIND_W-1:0] kind,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [POS_W-1:0]  read_position,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [POS_W-1:0]  text_length,
  input  logic [POS_W-1:0]  cursor_position,
  input  logic [CHAR_W-1:0] read_char,
  input  logic              changed,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [CAP_W-1:0]  cfg_data,
  output int                mismatches,
  output int                awaited
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [POS_W-1:0]  len;
    logic [POS_W-1:0]  cur;
    logic [CHAR_W-1:0] rd;
    logic              chg;
  } line_status_t;

  logic [CHAR_W-1:0] cells [MAX_CHARS];
  int unsigned       text_len;
  int unsigned       cursor;
  int unsigned       capacity;
  int unsigned       start_pos;
  line_status_t      pending_status [$];

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] %s", $realtime, msg);
  endtask

  task automatic apply_edit(input kind_t k, input logic [CHAR_W-1:0] ch,
                            input logic [POS_W-1:0] pos);
    line_status_t st;
    int unsigned  room;
    st = '0;
    room = (capacity > MAX_CHARS) ? MAX_CHARS : capacity;
    case (k)
      KIND_LEFT: begin
        if (cursor > start_pos) begin
          cursor--;
          st.chg = 1'b1;
        end
      end
      KIND_RIGHT: begin
        if (cursor + 1 < text_len) begin
          cursor++;
          st.chg = 1'b1;
        end
      end
      KIND_BKSP: begin
        if (cursor > start_pos && cursor > 0 && text_len > 0) begin
          for (int i = cursor; i < text_len && i < MAX_CHARS; i++) cells[i-1] = cells[i];
          cursor--;
          text_len--;
          st.chg = 1'b1;
        end
      end
      KIND_INSERT: begin
        if (text_len + 1 < room && cursor <= text_len) begin
          for (int i = text_len; i > cursor; i--) cells[i] = cells[i-1];
          cells[cursor] = ch;
          cursor++;
          text_len++;
          st.chg = 1'b1;
        end
      end
      KIND_READ: begin
        if (pos < text_len && pos < MAX_CHARS) st.rd = cells[pos];
      end
      KIND_CLEAR: begin
        st.chg = (text_len != 0 || cursor != 0);
        text_len = 0;
        cursor = 0;
      end
      default: begin
      end
    endcase
    st.len = POS_W'(text_len);
    st.cur = POS_W'(cursor);
    pending_status.push_back(st);
  endtask

  always @(posedge clk) begin
    line_status_t want;
    if (rst) begin
      foreach (cells[i]) cells[i] = '0;
      text_len = 0;
      cursor = 0;
      capacity = CAP_RESET;
      start_pos = START_RESET;
      pending_status.delete();
      mismatches = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_status.size() == 0) begin
          report_mismatch("result arrived with no request waiting for it");
        end else begin
          want = pending_status.pop_front();
          if (text_length !== want.len)
            report_mismatch($sformatf("text_length got %0d expected %0d", text_length, want.len));
          if (cursor_position !== want.cur)
            report_mismatch($sformatf("cursor_position got %0d expected %0d",
                                      cursor_position, want.cur));
          if (read_char !== want.rd)
            report_mismatch($sformatf("read_char got %h expected %h", read_char, want.rd));
          if (changed !== want.chg)
            report_mismatch($sformatf("changed got %b expected %b", changed, want.chg));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_CAPACITY: capacity = cfg_data;
          CFG_START:    start_pos = cfg_data[POS_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) apply_edit(kind_t'(kind), char_code, read_position);
    end
    awaited <= pending_status.size();
  end

endmodule

// ----- sim/tb.sv -----
// Testbench top: clock, reset, editing requests, register writes and the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import leb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [KIND_W-1:0] kind = KIND_NONE;
  logic [CHAR_W-1:0] char_code = '0;
  logic [POS_W-1:0]  read_position = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [POS_W-1:0]  text_length;
  logic [POS_W-1:0]  cursor_position;
  logic [CHAR_W-1:0] read_char;
  logic              changed;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_index = CFG_CAPACITY;
  logic [CAP_W-1:0]  cfg_data = '0;

  int in_idle_pct = 15;
  int out_stall_pct = 15;
  int cycles = 0;
  int mismatches;
  int awaited;

  line_edit_buffer_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .char_code(char_code), .read_position(read_position),
    .out_valid(out_valid), .out_stall(out_stall),
    .text_length(text_length), .cursor_position(cursor_position),
    .read_char(read_char), .changed(changed),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  line_status_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .char_code(char_code), .read_position(read_position),
    .out_valid(out_valid), .out_stall(out_stall),
    .text_length(text_length), .cursor_position(cursor_position),
    .read_char(read_char), .changed(changed),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .awaited(awaited)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) out_stall <= !rst && ($urandom_range(0, 99) < out_stall_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_req(input kind_t k, input logic [CHAR_W-1:0] ch,
                          input logic [POS_W-1:0] pos);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    char_code <= ch;
    read_position <= pos;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_limits(input logic [CAP_W-1:0] cap, input logic [CAP_W-1:0] start);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_CAPACITY;
    cfg_data <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_START;
    cfg_data <= start;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random(input int ins_pct);
    int    roll;
    kind_t k;
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) begin
      k = KIND_INSERT;
    end else begin
      roll = $urandom_range(0, 99);
      k = roll < 22 ? KIND_LEFT :
          roll < 44 ? KIND_RIGHT :
          roll < 68 ? KIND_BKSP :
          roll < 90 ? KIND_READ :
          roll < 94 ? KIND_CLEAR :
          roll < 97 ? KIND_NONE : KIND_SPARE;
    end
    send_req(k, CHAR_W'($urandom),
             ($urandom_range(0, 3) == 0) ? POS_W'($urandom) : POS_W'($urandom_range(0, 15)));
  endtask

  task automatic run_phase(input logic [CAP_W-1:0] cap, input logic [CAP_W-1:0] start,
                           input int ins_pct, input int count, input bit quiet);
    wait_drained();
    set_limits(cap, start);
    in_idle_pct = quiet ? 0 : 15;
    out_stall_pct = quiet ? 0 : 15;
    repeat (count) send_random(ins_pct);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_req(KIND_NONE, 8'hFF, 6'h3F);
    send_req(KIND_SPARE, 8'h00, 6'h00);
    send_req(KIND_RIGHT, 8'h00, 6'h00);
    send_req(KIND_LEFT, 8'h00, 6'h00);
    send_req(KIND_BKSP, 8'h00, 6'h00);
    send_req(KIND_READ, 8'h00, 6'h00);
    send_req(KIND_CLEAR, 8'h00, 6'h00);
    send_req(KIND_INSERT, 8'h00, 6'h00);
    send_req(KIND_INSERT, 8'hFF, 6'h00);
    send_req(KIND_INSERT, 8'hA5, 6'h00);
    send_req(KIND_INSERT, 8'h5A, 6'h00);
    send_req(KIND_LEFT, 8'h00, 6'h00);
    send_req(KIND_LEFT, 8'h00, 6'h00);
    send_req(KIND_INSERT, 8'h3C, 6'h00);
    send_req(KIND_RIGHT, 8'h00, 6'h00);
    send_req(KIND_RIGHT, 8'h00, 6'h00);
    send_req(KIND_RIGHT, 8'h00, 6'h00);
    send_req(KIND_READ, 8'h00, 6'd0);
    send_req(KIND_READ, 8'h00, 6'd4);
    send_req(KIND_READ, 8'h00, 6'd5);
    send_req(KIND_READ, 8'h00, 6'h3F);
    send_req(KIND_BKSP, 8'h00, 6'h00);
    send_req(KIND_CLEAR, 8'h00, 6'h00);
    send_req(KIND_CLEAR, 8'h00, 6'h00);

    run_phase(7'd64, 7'd0, 85, 120, 1'b0);
    run_phase(7'd64, 7'd0, 45, 100, 1'b1);
    run_phase(7'd2, 7'd0, 50, 60, 1'b0);
    run_phase(7'd0, 7'd0, 50, 40, 1'b0);
    run_phase(7'd1, 7'd5, 50, 40, 1'b0);
    run_phase(7'd127, 7'd5, 55, 120, 1'b0);
    run_phase(7'd16, 7'h7F, 50, 60, 1'b0);
    run_phase(7'd40, 7'd12, 55, 120, 1'b0);
    run_phase(CAP_W'($urandom), CAP_W'($urandom), 50, 100, 1'b0);
    run_phase(CAP_W'($urandom_range(20, 127)), CAP_W'($urandom_range(0, 20)), 60, 140, 1'b0);

    wait_drained();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
